// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the rtl of the rail patrol speed sequencer
// no dependencies; the assertions drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// condition holds at every clock edge out of reset
`define RPSS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// antecedent at one edge implies consequent at the next edge
`define RPSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RPSS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define RPSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/rpss_pkg.sv -----
// shared types, constants and speed tables of the rail patrol speed sequencer
// no dependencies
`default_nettype none
package rpss_pkg;

    localparam int unsigned WAIT_W = 16;
    localparam int unsigned MOVE_W = 8;
    localparam int unsigned SPEED_W = 14;
    localparam int unsigned MAG_W = 13;
    localparam int unsigned POS_W = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_THR = 2'd2;

    // sensor codes
    localparam logic [1:0] SENSE_IDLE = 2'd0;
    localparam logic [1:0] SENSE_LEFT = 2'd1;
    localparam logic [1:0] SENSE_RIGHT = 2'd2;
    localparam logic [1:0] SENSE_BOTH = 2'd3;

    // rail segment codes
    localparam logic [1:0] SEG_LEFT = 2'd0;
    localparam logic [1:0] SEG_MIDDLE = 2'd1;
    localparam logic [1:0] SEG_RIGHT = 2'd2;

    localparam logic MODE_PATROL = 1'b0;
    localparam logic MODE_SLOW = 1'b1;

    localparam logic [WAIT_W-1:0] WAIT_RELEASE = 16'd50;
    localparam logic [WAIT_W-1:0] WAIT_REARM = 16'd49;
    localparam logic [WAIT_W-1:0] WAIT_MAX = 16'hFFFF;
    localparam logic [MOVE_W-1:0] MOVE_MAX = 8'hFF;

    localparam logic [POS_W-1:0] LEFT_THR_RESET = 16'd4000;
    localparam logic [POS_W-1:0] RIGHT_THR_RESET = 16'd18469;

    localparam logic [MAG_W-1:0] SPEED_TOP = 13'd5800;

    localparam logic [MAG_W-1:0] PATROL_STEPS [8] = '{
        13'd3000, 13'd3500, 13'd4000, 13'd4500, 13'd5000, 13'd5200, 13'd5500, 13'd5800
    };
    localparam logic [MAG_W-1:0] SLOW_STEPS [8] = '{
        13'd1500, 13'd2000, 13'd2500, 13'd3200, 13'd4000, 13'd4300, 13'd5200, 13'd5800
    };

    typedef struct packed {
        logic [1:0]       limit_state;
        logic [1:0]       photo_state;
        logic [POS_W-1:0] position;
        logic             under_attack;
    } item_t;

    typedef struct packed {
        logic             mode;
        logic [POS_W-1:0] left_thr;
        logic [POS_W-1:0] right_thr;
    } cfg_t;

    typedef struct packed {
        logic [WAIT_W-1:0]         wait_count;
        logic [MOVE_W-1:0]         move_count;
        logic                      direction_right;
        logic                      photo_seen;
        logic signed [SPEED_W-1:0] held_setpoint;
        logic [1:0]                rail_segment;
    } state_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed_setpoint;
        logic                      moving_right;
        logic                      drive_enable;
        logic                      photo_error;
    } result_t;

    function automatic logic [MAG_W-1:0] step_mag(input logic slow, input logic [2:0] idx);
        step_mag = slow ? SLOW_STEPS[idx] : PATROL_STEPS[idx];
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/rpss_core.sv -----
// next-state and result logic for one tick of the speed sequencer
// depends on rpss_pkg
`default_nettype none
module rpss_core (
    input  wire rpss_pkg::cfg_t    cfg,
    input  wire rpss_pkg::state_t  cur,
    input  wire rpss_pkg::item_t   item,
    output rpss_pkg::state_t  nxt,
    output rpss_pkg::result_t res
);
    import rpss_pkg::*;

    logic [WAIT_W-1:0]         wait_inc;
    logic [MOVE_W-1:0]         move_inc;
    logic [WAIT_W-1:0]         wait_s;
    logic [MOVE_W-1:0]         move_s;
    logic                      dir_s;
    logic                      seen_s;
    logic [1:0]                seg_s;
    logic [2:0]                step_idx;
    logic                      step_load;
    logic [MAG_W-1:0]          mag;
    logic signed [SPEED_W-1:0] speed;
    logic signed [SPEED_W-1:0] sp_s;
    logic                      slow;

    assign slow = (cfg.mode == MODE_SLOW);
    assign wait_inc = (cur.wait_count == WAIT_MAX) ? cur.wait_count : cur.wait_count + 16'd1;
    assign move_inc = (cur.move_count == MOVE_MAX) ? cur.move_count : cur.move_count + 8'd1;

    // sensor stage then limit stage
    always_comb
    begin
        wait_s = cur.wait_count;
        move_s = cur.move_count;
        dir_s  = cur.direction_right;
        seen_s = cur.photo_seen;
        if (!slow)
        begin
            priority if (item.limit_state == SENSE_IDLE)
            begin
                wait_s = '0;
                move_s = move_inc;
                seen_s = 1'b0;
            end
            else if (item.photo_state == SENSE_LEFT || item.photo_state == SENSE_RIGHT)
            begin
                wait_s = wait_inc;
                move_s = '0;
                seen_s = 1'b1;
            end
            else if (item.photo_state == SENSE_BOTH)
            begin
                wait_s = 16'd1;
                move_s = '0;
            end
            else
            begin
                // limit active with photos idle: counters left to the limit stage
            end
        end
        else
        begin
            priority if (item.photo_state == SENSE_IDLE || item.limit_state == SENSE_IDLE)
            begin
                wait_s = '0;
                move_s = move_inc;
            end
            else if (item.photo_state == SENSE_LEFT || item.photo_state == SENSE_RIGHT)
            begin
                wait_s = wait_inc;
                move_s = '0;
            end
            else
            begin
                wait_s = 16'd1;
                move_s = '0;
            end
        end

        priority if (item.limit_state == SENSE_LEFT || item.limit_state == SENSE_RIGHT)
        begin
            dir_s  = (item.limit_state == SENSE_LEFT);
            move_s = '0;
            if (!slow && !seen_s)
            begin
                wait_s = WAIT_REARM;
            end
            else if (slow && item.photo_state == SENSE_IDLE)
            begin
                wait_s = '0;
            end
        end
        else if (item.limit_state == SENSE_BOTH)
        begin
            wait_s = 16'd1;
            move_s = '0;
        end
        else
        begin
            // no limit switch: sensor stage result stands
        end
    end

    // rail segment, only tracked in slow mode
    always_comb
    begin
        seg_s = cur.rail_segment;
        if (slow)
        begin
            priority if (item.position < cfg.left_thr)
                seg_s = SEG_LEFT;
            else if (item.position <= cfg.right_thr)
                seg_s = SEG_MIDDLE;
            else
                seg_s = SEG_RIGHT;
        end
    end

    // speed staircase: pick the step; the first step loads on a zero move count, the higher steps need a zero dwell
    always_comb
    begin
        step_idx  = 3'd0;
        step_load = 1'b0;
        if (move_s == '0)
        begin
            step_load = 1'b1;
        end
        else if (wait_s == '0)
        begin
            step_load = 1'b1;
            priority if (move_s > 8'd100 && move_s < 8'd150)
                step_idx = 3'd7;
            else if (move_s > 8'd70)
                step_idx = 3'd6;
            else if (move_s > 8'd60)
                step_idx = 3'd5;
            else if (move_s > 8'd50)
                step_idx = 3'd4;
            else if (move_s > 8'd30)
                step_idx = 3'd3;
            else if (move_s > 8'd20)
                step_idx = 3'd2;
            else if (move_s > 8'd10)
                step_idx = 3'd1;
            else
                step_load = 1'b0;
        end
    end

    assign mag = step_mag(slow, step_idx);
    assign speed = dir_s ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    always_comb
    begin
        sp_s = cur.held_setpoint;
        if (move_s == '0 && wait_s < WAIT_RELEASE)
            sp_s = '0;
        else if (step_load)
            sp_s = speed;
    end

    always_comb
    begin
        nxt.wait_count      = wait_s;
        nxt.move_count      = (!slow && !item.under_attack) ? '0 : move_s;
        nxt.direction_right = dir_s;
        nxt.photo_seen      = seen_s;
        nxt.held_setpoint   = sp_s;
        nxt.rail_segment    = seg_s;

        res.speed_setpoint  = sp_s;
        res.moving_right    = dir_s;
        res.drive_enable    = slow || item.under_attack;
        res.photo_error     = (item.photo_state == SENSE_RIGHT) && (seg_s == SEG_MIDDLE);
    end

endmodule
`default_nettype wire

// ----- hw/rtl/rail_patrol_speed_sequencer_top.sv -----
// top level of the rail patrol speed sequencer: handshakes, registers, state
// depends on rpss_pkg, rpss_core and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
//
//  channel   direction  handshake              payload
//  input     in         in_valid / in_ready    limit_state photo_state position under_attack
//  result    out        out_valid / out_ready  speed_setpoint moving_right drive_enable
//                                              photo_error
//  config    in         cfg_valid / cfg_ready  cfg_index cfg_data
//
//  one request per cycle sustained while out_ready is high; a request is taken
//  into the input register, and the tick logic then runs on it and loads the
//  result register once the result stage is free or being emptied;
//  a stalled result holds the result register and the input register in turn;
//  in_ready drops only when both are full and out_ready is low
//  reset clears the sequencer state and loads the threshold defaults;
//  config writes are taken in any cycle (cfg_ready is always high)
//
module rail_patrol_speed_sequencer_top (
    input  wire                                 clk,
    input  wire                                 rst_n,

    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  [1:0]                          limit_state,
    input  wire  [1:0]                          photo_state,
    input  wire  [rpss_pkg::POS_W-1:0]          position,
    input  wire                                 under_attack,

    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic signed [rpss_pkg::SPEED_W-1:0] speed_setpoint,
    output logic                                moving_right,
    output logic                                drive_enable,
    output logic                                photo_error,

    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [rpss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [rpss_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rpss_pkg::*;

    // configuration registers
    cfg_t    cfg_reg;
    // sequencer state carried from tick to tick
    state_t  state_reg;
    state_t  state_next;
    // input stage
    logic    in_valid_reg;
    item_t   item_reg;
    // result stage
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;

    logic    in_take;
    logic    advance;

    // the tick runs when the input stage holds a request and the result
    // stage is free or being emptied this cycle
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // configuration writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= MODE_PATROL;
            cfg_reg.left_thr  <= LEFT_THR_RESET;
            cfg_reg.right_thr <= RIGHT_THR_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE:      cfg_reg.mode      <= cfg_data[0];
                REG_LEFT_THR:  cfg_reg.left_thr  <= cfg_data;
                REG_RIGHT_THR: cfg_reg.right_thr <= cfg_data;
                default:       ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.limit_state  <= limit_state;
            item_reg.photo_state  <= photo_state;
            item_reg.position     <= position;
            item_reg.under_attack <= under_attack;
        end
    end

    // per-tick logic: sensor stage, limit stage, segment, staircase
    rpss_core u_core (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (result_next)
    );

    // state commits only when the tick's result is loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid      = out_valid_reg;
    assign speed_setpoint = result_reg.speed_setpoint;
    assign moving_right   = result_reg.moving_right;
    assign drive_enable   = result_reg.drive_enable;
    assign photo_error    = result_reg.photo_error;

    // every tick leaves at least one of the two counters at zero
    `RPSS_ASSERT_ALWAYS(a_counters_exclusive, clk, rst_n, state_reg.wait_count == '0 || state_reg.move_count == '0, "wait and move counters both nonzero")
    // held setpoint stays within the staircase range
    `RPSS_ASSERT_ALWAYS(a_setpoint_range, clk, rst_n, state_reg.held_setpoint <= $signed({1'b0, SPEED_TOP}) && state_reg.held_setpoint >= -$signed({1'b0, SPEED_TOP}), "held setpoint out of range")
    // a pending request moves to the free result stage on the next edge
    `RPSS_ASSERT_NEXT(a_stage_advance, clk, rst_n, in_valid_reg && !out_valid_reg, out_valid_reg, "request stuck in the input stage")

endmodule
`default_nettype wire

// ----- tb/sv/rpss_tb_pkg.sv -----
// scoreboard for the rail patrol speed sequencer testbench: a cycle-free copy
// of the tick logic and the queue of predicted results
// depends on rpss_pkg for the item and result types and the codes
package rpss_tb_pkg;

    import rpss_pkg::*;

    class speed_scoreboard;

        // register copy
        logic                      mode;
        logic [POS_W-1:0]          left_thr;
        logic [POS_W-1:0]          right_thr;

        // sequencer state copy
        logic [WAIT_W-1:0]         wait_cnt;
        logic [MOVE_W-1:0]         move_cnt;
        logic                      dir_right;
        logic                      photo_seen;
        logic signed [SPEED_W-1:0] held_sp;
        logic [1:0]                segment;

        result_t                   predicted_results[$];
        int unsigned               mismatches;

        function new();
            mode       = MODE_PATROL;
            left_thr   = LEFT_THR_RESET;
            right_thr  = RIGHT_THR_RESET;
            wait_cnt   = '0;
            move_cnt   = '0;
            dir_right  = 1'b0;
            photo_seen = 1'b0;
            held_sp    = '0;
            segment    = SEG_LEFT;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MODE:      mode = data[0];
                REG_LEFT_THR:  left_thr = data;
                REG_RIGHT_THR: right_thr = data;
                default:       ;
            endcase
        endfunction

        function int pending();
            return predicted_results.size();
        endfunction

        // speed staircase, one table per mode
        function int stair_mag(int idx);
            case (idx)
                0:       return (mode == MODE_SLOW) ? 1500 : 3000;
                1:       return (mode == MODE_SLOW) ? 2000 : 3500;
                2:       return (mode == MODE_SLOW) ? 2500 : 4000;
                3:       return (mode == MODE_SLOW) ? 3200 : 4500;
                4:       return (mode == MODE_SLOW) ? 4000 : 5000;
                5:       return (mode == MODE_SLOW) ? 4300 : 5200;
                6:       return 5200 + ((mode == MODE_SLOW) ? 0 : 300);
                default: return 5800;
            endcase
        endfunction

        function int step_speed(int idx);
            return dir_right ? -stair_mag(idx) : stair_mag(idx);
        endfunction

        function void bump_wait();
            if (wait_cnt != WAIT_MAX) wait_cnt++;
        endfunction

        function void bump_move();
            if (move_cnt != MOVE_MAX) move_cnt++;
        endfunction

        function void refresh_setpoint();
            int sp;
            sp = held_sp;
            if (wait_cnt < WAIT_RELEASE && move_cnt == 0) begin
                sp = 0;
            end else if (wait_cnt >= WAIT_RELEASE && move_cnt == 0) begin
                sp = step_speed(0);
            end else if (wait_cnt == 0) begin
                if (move_cnt > 10) sp = step_speed(1);
                if (move_cnt > 20) sp = step_speed(2);
                if (move_cnt > 30) sp = step_speed(3);
                if (move_cnt > 50) sp = step_speed(4);
                if (move_cnt > 60) sp = step_speed(5);
                if (move_cnt > 70) sp = step_speed(6);
                // top step only inside its window, past it the previous step stays
                if (move_cnt > 100 && move_cnt < 150) sp = step_speed(7);
            end
            held_sp = sp[SPEED_W-1:0];
        endfunction

        // one control tick
        function result_t tick(item_t it);
            result_t r;
            logic    drive;
            logic    perr;
            if (mode == MODE_PATROL) begin
                if (it.limit_state == SENSE_IDLE) begin
                    wait_cnt   = '0;
                    bump_move();
                    photo_seen = 1'b0;
                end else if (it.photo_state == SENSE_LEFT || it.photo_state == SENSE_RIGHT) begin
                    bump_wait();
                    move_cnt   = '0;
                    photo_seen = 1'b1;
                end else if (it.photo_state == SENSE_BOTH) begin
                    wait_cnt = 16'd1;
                    move_cnt = '0;
                end
                if (it.limit_state == SENSE_LEFT || it.limit_state == SENSE_RIGHT) begin
                    dir_right = (it.limit_state == SENSE_LEFT);
                    if (!photo_seen) wait_cnt = WAIT_REARM;
                    move_cnt = '0;
                end else if (it.limit_state == SENSE_BOTH) begin
                    wait_cnt = 16'd1;
                    move_cnt = '0;
                end
                // segment is only held in patrol
                perr = (it.photo_state == SENSE_RIGHT && segment == SEG_MIDDLE);
                refresh_setpoint();
                drive = it.under_attack;
                if (!it.under_attack) move_cnt = '0;
            end else begin
                if (it.photo_state == SENSE_IDLE || it.limit_state == SENSE_IDLE) begin
                    wait_cnt = '0;
                    bump_move();
                end else if (it.photo_state == SENSE_LEFT || it.photo_state == SENSE_RIGHT) begin
                    bump_wait();
                    move_cnt = '0;
                end else begin
                    wait_cnt = 16'd1;
                    move_cnt = '0;
                end
                if (it.limit_state == SENSE_LEFT || it.limit_state == SENSE_RIGHT) begin
                    dir_right = (it.limit_state == SENSE_LEFT);
                    if (it.photo_state == SENSE_IDLE) wait_cnt = '0;
                    move_cnt = '0;
                end else if (it.limit_state == SENSE_BOTH) begin
                    wait_cnt = 16'd1;
                    move_cnt = '0;
                end
                if (it.position < left_thr) segment = SEG_LEFT;
                else if (it.position <= right_thr) segment = SEG_MIDDLE;
                else segment = SEG_RIGHT;
                perr = (it.photo_state == SENSE_RIGHT && segment == SEG_MIDDLE);
                refresh_setpoint();
                drive = 1'b1;
            end
            r.speed_setpoint = held_sp;
            r.moving_right   = dir_right;
            r.drive_enable   = drive;
            r.photo_error    = perr;
            return r;
        endfunction

        function void note_request(item_t it);
            predicted_results.push_back(tick(it));
        endfunction

        function void check_result(logic signed [SPEED_W-1:0] sp, logic right,
                                   logic drive, logic perr);
            result_t want;
            if (predicted_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no request pending: sp=%0d right=%0b drive=%0b perr=%0b",
                             sp, right, drive, perr);
                return;
            end
            want = predicted_results.pop_front();
            if (sp !== want.speed_setpoint || right !== want.moving_right ||
                drive !== want.drive_enable || perr !== want.photo_error) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: want sp=%0d right=%0b drive=%0b perr=%0b, got sp=%0d right=%0b drive=%0b perr=%0b",
                             want.speed_setpoint, want.moving_right, want.drive_enable,
                             want.photo_error, sp, right, drive, perr);
            end
        endfunction

    endclass

endpackage

// ----- tb/sv/tb_rail_patrol_speed_sequencer_top.sv -----
// top level testbench of the rail patrol speed sequencer: clock, reset, request
// and result drivers, config writes and the stimulus plan
// depends on rpss_pkg, rpss_tb_pkg and rail_patrol_speed_sequencer_top
module tb_rail_patrol_speed_sequencer_top;

    timeunit 1ns;
    timeprecision 1ps;

    import rpss_pkg::*;
    import rpss_tb_pkg::*;

    // index with no register behind it, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned DRAIN_CYCLES  = 4;
    localparam int unsigned PRESSURE_HOLD = 300;
    localparam int unsigned PHASE_ITEMS   = 40;
    localparam int unsigned DWELL_TICKS   = 60;
    localparam int unsigned RUN_TICKS     = 270;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [1:0]                limit_state = '0;
    logic [1:0]                photo_state = '0;
    logic [POS_W-1:0]          position = '0;
    logic                      under_attack = 1'b0;

    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [SPEED_W-1:0] speed_setpoint;
    logic                      moving_right;
    logic                      drive_enable;
    logic                      photo_error;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;

    speed_scoreboard sb = new();

    // stimulus bookkeeping
    int unsigned      req_count = 0;
    int unsigned      cycle_count = 0;
    bit               quiet = 1'b0;
    bit               pressure_armed = 1'b0;
    logic [POS_W-1:0] cur_left = LEFT_THR_RESET;
    logic [POS_W-1:0] cur_right = RIGHT_THR_RESET;

    rail_patrol_speed_sequencer_top dut (.*);

    always #4 clk = ~clk;

    // run limit, far above the slowest legal run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("rail_patrol_speed_sequencer_top regression: fail");
            $finish;
        end
    end

    // idle length for either side: mostly none, sometimes short, rarely long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // position: uniform, rail ends, or close to one of the thresholds
    function automatic logic [POS_W-1:0] pick_position();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4) return 16'($urandom);
        if (r < 5) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if (r < 7) return cur_left + 16'($urandom_range(0, 6)) - 16'd3;
        return cur_right + 16'($urandom_range(0, 6)) - 16'd3;
    endfunction

    function automatic item_t mk(logic [1:0] lim, logic [1:0] pho, logic [POS_W-1:0] pos,
                                 logic atk);
        item_t it;
        it.limit_state  = lim;
        it.photo_state  = pho;
        it.position     = pos;
        it.under_attack = atk;
        return it;
    endfunction

    // result side: random back-pressure, plus one long hold-off once armed so
    // that the result and input registers both fill and in_ready drops
    int unsigned stall_left = 0;
    bit          pressure_done = 1'b0;

    always @(negedge clk) begin
        if (pressure_armed && !pressure_done) begin
            pressure_done = 1'b1;
            stall_left = PRESSURE_HOLD;
        end
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else begin
            out_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // result monitor, sampled at the rising edge
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(speed_setpoint, moving_right, drive_enable, photo_error);
    end

    // one request; entered and left at a falling edge, valid stays high when
    // the next request follows without a gap
    task automatic send_req(input item_t it);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        limit_state  <= it.limit_state;
        photo_state  <= it.photo_state;
        position     <= it.position;
        under_attack <= it.under_attack;
        do @(posedge clk); while (!in_ready);
        sb.note_request(it);
        req_count++;
        @(negedge clk);
    endtask

    // stop offering, wait for every predicted result, then let the pipe empty
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // register write; cfg_valid is left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    // full register set, only with the block idle
    task automatic apply_config(input logic m, input logic [POS_W-1:0] lthr,
                                input logic [POS_W-1:0] rthr);
        settle();
        // upper bits of the mode word are junk and must be dropped
        write_reg(REG_MODE, {15'($urandom), m});
        write_reg(REG_LEFT_THR, lthr);
        write_reg(REG_RIGHT_THR, rthr);
        write_reg(REG_SPARE, 16'($urandom));
        cfg_valid <= 1'b0;
        cur_left  = lthr;
        cur_right = rthr;
    endtask

    // parked at a rail end with the photo sensor seeing the marker
    task automatic send_dwell(input int unsigned n);
        logic [1:0]  side;
        logic [1:0]  pho;
        int unsigned k;
        if ($urandom_range(0, 9) == 0) side = SENSE_BOTH;
        else side = $urandom_range(0, 1) ? SENSE_LEFT : SENSE_RIGHT;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 7) != 0) pho = $urandom_range(0, 1) ? SENSE_LEFT : SENSE_RIGHT;
            else pho = 2'($urandom);
            send_req(mk(side, pho, pick_position(), 1'($urandom)));
        end
    endtask

    // travel along the rail, occasionally interrupted by a switch or no attack
    task automatic send_run(input int unsigned n);
        logic [1:0]  lim;
        logic        atk;
        int unsigned k;
        for (k = 0; k < n; k++) begin
            lim = ($urandom_range(0, 39) == 0) ? 2'($urandom) : SENSE_IDLE;
            atk = ($urandom_range(0, 29) != 0);
            send_req(mk(lim, 2'($urandom), pick_position(), atk));
        end
    endtask

    task automatic send_noise(input int unsigned n);
        int unsigned k;
        for (k = 0; k < n; k++)
            send_req(mk(2'($urandom), 2'($urandom), 16'($urandom), 1'($urandom)));
    endtask

    initial begin
        int unsigned phase;
        int unsigned start;
        int unsigned k;
        logic [POS_W-1:0] lthr;
        logic [POS_W-1:0] rthr;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed patrol ticks from reset: rearm at an end with photos idle,
        // release after the dwell, drive off without attack, both switches
        send_req(mk(SENSE_IDLE, SENSE_IDLE, 16'h0000, 1'b0));
        send_req(mk(SENSE_LEFT, SENSE_IDLE, 16'hFFFF, 1'b1));
        send_req(mk(SENSE_LEFT, SENSE_LEFT, 16'h5555, 1'b1));
        send_req(mk(SENSE_RIGHT, SENSE_RIGHT, 16'hAAAA, 1'b0));
        // limit active with photos idle keeps the counters
        send_req(mk(SENSE_RIGHT, SENSE_IDLE, 16'd1, 1'b1));
        send_req(mk(SENSE_IDLE, SENSE_BOTH, 16'd2, 1'b1));
        send_req(mk(SENSE_IDLE, SENSE_LEFT, 16'd3, 1'b0));
        send_req(mk(SENSE_BOTH, SENSE_BOTH, 16'd4, 1'b1));
        send_req(mk(SENSE_BOTH, SENSE_IDLE, 16'd5, 1'b1));
        send_req(mk(SENSE_LEFT, SENSE_BOTH, 16'd6, 1'b1));
        send_req(mk(SENSE_RIGHT, SENSE_LEFT, 16'd7, 1'b1));
        send_req(mk(SENSE_IDLE, SENSE_RIGHT, 16'hFFFF, 1'b1));

        // directed slow ticks with the reset thresholds, segment edges on both sides
        apply_config(MODE_SLOW, LEFT_THR_RESET, RIGHT_THR_RESET);
        send_req(mk(SENSE_IDLE, SENSE_IDLE, LEFT_THR_RESET - 16'd1, 1'b1));
        send_req(mk(SENSE_LEFT, SENSE_RIGHT, LEFT_THR_RESET, 1'b0));
        send_req(mk(SENSE_RIGHT, SENSE_BOTH, RIGHT_THR_RESET, 1'b1));
        send_req(mk(SENSE_LEFT, SENSE_IDLE, RIGHT_THR_RESET + 16'd1, 1'b1));
        send_req(mk(SENSE_BOTH, SENSE_LEFT, 16'h0000, 1'b1));
        send_req(mk(SENSE_RIGHT, SENSE_RIGHT, 16'hFFFF, 1'b0));
        send_req(mk(SENSE_IDLE, SENSE_RIGHT, 16'd10000, 1'b1));
        send_req(mk(SENSE_IDLE, SENSE_LEFT, 16'd100, 1'b0));
        send_req(mk(SENSE_BOTH, SENSE_BOTH, 16'd20000, 1'b1));
        send_req(mk(SENSE_IDLE, SENSE_IDLE, LEFT_THR_RESET, 1'b1));

        // back-to-back stretch in patrol: a dwell long enough to release
        // motion, then a run long enough to pin the move counter and pass the
        // end of the staircase
        apply_config(MODE_PATROL, 16'($urandom), 16'($urandom));
        quiet = 1'b1;
        for (k = 0; k < DWELL_TICKS; k++)
            send_req(mk($urandom_range(0, 1) ? SENSE_LEFT : SENSE_RIGHT,
                        $urandom_range(0, 1) ? SENSE_LEFT : SENSE_RIGHT,
                        16'($urandom), 1'($urandom)));
        for (k = 0; k < RUN_TICKS; k++)
            send_req(mk(SENSE_IDLE, 2'($urandom), 16'($urandom), 1'b1));
        quiet = 1'b0;

        // random phases, one register setting each
        for (phase = 0; phase < 7; phase++) begin
            lthr = 16'($urandom);
            rthr = 16'($urandom);
            case (phase)
                0: apply_config(MODE_SLOW, 16'h0000, 16'hFFFF);
                1: apply_config(MODE_PATROL, lthr, rthr);
                // crossed thresholds, fully and partly
                2: apply_config(MODE_SLOW, 16'hFFFF, 16'h0000);
                3: apply_config(MODE_SLOW, 16'd30000, 16'd10000);
                4: apply_config(MODE_SLOW, lthr, lthr);
                5: apply_config(MODE_PATROL, 16'h0000, 16'h0000);
                default: apply_config(MODE_SLOW, lthr, rthr);
            endcase
            if (phase == 2) pressure_armed = 1'b1;
            start = req_count;
            while (req_count - start < PHASE_ITEMS) begin
                if ($urandom_range(0, 3) != 0) begin
                    // dwell straddles the release count, run mostly short
                    send_dwell($urandom_range(30, 70));
                    if ($urandom_range(0, 7) == 0) send_run($urandom_range(150, 290));
                    else send_run($urandom_range(5, 60));
                end else begin
                    send_noise($urandom_range(3, 25));
                end
            end
        end

        settle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("rail_patrol_speed_sequencer_top regression: pass");
        else
            $display("rail_patrol_speed_sequencer_top regression: fail");
        $finish;
    end

endmodule

// ----- rail_patrol_speed_sequencer_top.f -----
+incdir+hw/rtl
hw/rtl/rpss_pkg.sv
hw/rtl/rpss_core.sv
hw/rtl/rail_patrol_speed_sequencer_top.sv
tb/sv/rpss_tb_pkg.sv
tb/sv/tb_rail_patrol_speed_sequencer_top.sv
